// ===== design/delta_position_list_decoder_top_assert.svh =====
// Assertion macros shared by the checker of the position list decoder.
`ifndef DELTA_POSITION_LIST_DECODER_TOP_ASSERT_SVH
`define DELTA_POSITION_LIST_DECODER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DPLD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DPLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dpld_pkg.sv =====
// Shared types and constants of the delta position list decoder.
package dpld_pkg;

    localparam int WORD_BITS    = 32;
    localparam int RES_BITS     = 2 * WORD_BITS;
    localparam int RCOUNT_BITS  = 7;
    localparam int WIDTH_BITS   = 5;
    localparam int MAX_RESULTS  = 32;
    localparam int NRES_BITS    = 6;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_START_POSITION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_VALUE_COUNT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_VALUE    = 2'd2;

    // What the decode loop would do next with the current state.
    typedef enum logic [2:0] {
        STEP_WIDTH,
        STEP_DONE,
        STEP_START,
        STEP_ESC,
        STEP_DELTA,
        STEP_RAW,
        STEP_STALL
    } step_kind_t;

    typedef struct packed {
        logic load;
        logic restart;
        logic exec;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        step_kind_t kind;
        logic       n_full;
        logic       resid_full;
        logic       pend_valid;
        logic       out_free;
    } dp_status_t;

endpackage

// ===== design/delta_position_list_decoder_top.sv =====
// Delta position list decoder: stream words in, absolute positions out.
//
// Input channel (s_valid/s_ready): s_kind 0 carries the next 32 stream bits, MSB first;
// s_kind 1 restarts the block (accumulator loaded from start_position, no word out).
// Output channel (m_valid/m_ready): one word per decoded position with the block value,
// last_of_word on the final word caused by an input word and last_of_block on the
// value_count-th position. Config writes (cfg_we, cfg_index, cfg_data) land at once and
// must be made while the block is idle; the block itself does not enforce this.
// Flow: one input word at a time. A stream word is loaded, then decoded step by step (header
// width, escape field or position), then closed with the end test and the flush; a start
// item is taken without leaving the idle state. At most 32 positions come from one word;
// leftover bits wait for the next word.
// Each position is held one step in a pending register, then moves to the output
// register; a stalled receiver holds the decode loop only when both are full, and
// s_ready rises again while the last word still waits in the output register.
// Reset: synchronous active-low aresetn; config registers clear, decoding starts as
// after a start item, outputs empty.
module delta_position_list_decoder_top #(
    parameter int RAW_DELTA_BITS = 32
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic                                      s_kind,
    input  logic [dpld_pkg::WORD_BITS-1:0]            s_stream_word,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [dpld_pkg::WORD_BITS-1:0]            m_position,
    output logic signed [dpld_pkg::WORD_BITS-1:0]     m_item_value,
    output logic                                      m_last_of_word,
    output logic                                      m_last_of_block,
    input  logic                                      cfg_we,
    input  logic [dpld_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [dpld_pkg::WORD_BITS-1:0]            cfg_data
);

    dpld_pkg::dp_cmd_t    cmd;
    dpld_pkg::dp_status_t status;

    dpld_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .status  (status),
        .cmd     (cmd)
    );

    dpld_datapath #(
        .RAW_DELTA_BITS (RAW_DELTA_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .word_in         (s_stream_word),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_position      (m_position),
        .m_item_value    (m_item_value),
        .m_last_of_word  (m_last_of_word),
        .m_last_of_block (m_last_of_block)
    );

endmodule

// ===== design/dpld_datapath.sv =====
// Datapath: bit residue, decode state, config registers, pending and output words.
module dpld_datapath #(
    parameter int RAW_DELTA_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dpld_pkg::dp_cmd_t                     cmd,
    output dpld_pkg::dp_status_t                  status,
    input  logic [dpld_pkg::WORD_BITS-1:0]        word_in,
    input  logic                                  cfg_we,
    input  logic [dpld_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [dpld_pkg::WORD_BITS-1:0]        cfg_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [dpld_pkg::WORD_BITS-1:0]        m_position,
    output logic signed [dpld_pkg::WORD_BITS-1:0] m_item_value,
    output logic                                  m_last_of_word,
    output logic                                  m_last_of_block
);

    localparam logic [5:0] RAW_LEN   = 6'(RAW_DELTA_BITS);
    localparam logic [5:0] WIDTH_LEN = 6'(dpld_pkg::WIDTH_BITS);

    function automatic logic [dpld_pkg::WORD_BITS-1:0] low_mask(input logic [5:0] n);
        logic [dpld_pkg::WORD_BITS-1:0] m;
        if (n >= 6'(dpld_pkg::WORD_BITS)) begin
            m = '1;
        end else begin
            m = (32'd1 << n) - 32'd1;
        end
        return m;
    endfunction

    logic [dpld_pkg::WORD_BITS-1:0]        start_pos_reg;
    logic [dpld_pkg::WORD_BITS-1:0]        value_count_reg;
    logic signed [dpld_pkg::WORD_BITS-1:0] block_value_reg;

    logic [dpld_pkg::RES_BITS-1:0]    residue_reg;
    logic [dpld_pkg::RCOUNT_BITS-1:0] rcount_reg;
    logic [dpld_pkg::WIDTH_BITS-1:0]  dwidth_reg;
    logic                             wknown_reg;
    logic                             esc_reg;
    logic [dpld_pkg::WORD_BITS-1:0]   accum_reg;
    logic [dpld_pkg::WORD_BITS-1:0]   emitted_reg;
    logic [dpld_pkg::NRES_BITS-1:0]   nres_reg;

    logic                           pend_valid_reg;
    logic [dpld_pkg::WORD_BITS-1:0] pend_pos_reg;
    logic                           pend_lob_reg;

    logic                                  out_valid_reg;
    logic [dpld_pkg::WORD_BITS-1:0]        out_pos_reg;
    logic signed [dpld_pkg::WORD_BITS-1:0] out_val_reg;
    logic                                  out_low_reg;
    logic                                  out_lob_reg;

    logic [5:0]                       field_len;
    logic                             have_bits;
    logic [dpld_pkg::RCOUNT_BITS-1:0] shamt;
    logic [dpld_pkg::RES_BITS-1:0]    shifted;
    logic [dpld_pkg::WORD_BITS-1:0]   field;
    logic                             is_escape;
    logic [dpld_pkg::WORD_BITS-1:0]   sum;
    logic [dpld_pkg::WORD_BITS-1:0]   emitted_inc;
    logic [dpld_pkg::WORD_BITS-1:0]   emit_pos;
    dpld_pkg::step_kind_t             kind;
    logic                             emit;
    logic                             move;

    // Field under the read point: header width, raw delta or W-bit delta.
    always_comb begin
        if (!wknown_reg) begin
            field_len = WIDTH_LEN;
        end else if (esc_reg) begin
            field_len = RAW_LEN;
        end else begin
            field_len = {1'b0, dwidth_reg};
        end
    end

    assign have_bits   = rcount_reg >= {1'b0, field_len};
    assign shamt       = rcount_reg - {1'b0, field_len};
    assign shifted     = residue_reg >> shamt;
    assign field       = shifted[dpld_pkg::WORD_BITS-1:0] & low_mask(field_len);
    assign is_escape   = field == low_mask({1'b0, dwidth_reg});
    assign sum         = accum_reg + field;
    assign emitted_inc = emitted_reg + 32'd1;

    always_comb begin
        if (!wknown_reg) begin
            kind = have_bits ? dpld_pkg::STEP_WIDTH : dpld_pkg::STEP_STALL;
        end else if (emitted_reg >= value_count_reg) begin
            kind = dpld_pkg::STEP_DONE;
        end else if (emitted_reg == '0) begin
            kind = dpld_pkg::STEP_START;
        end else if (!have_bits) begin
            kind = dpld_pkg::STEP_STALL;
        end else if (esc_reg) begin
            kind = dpld_pkg::STEP_RAW;
        end else if (is_escape) begin
            kind = dpld_pkg::STEP_ESC;
        end else begin
            kind = dpld_pkg::STEP_DELTA;
        end
    end

    assign emit     = cmd.exec && (kind inside {dpld_pkg::STEP_START, dpld_pkg::STEP_DELTA,
                                                dpld_pkg::STEP_RAW});
    assign move     = pend_valid_reg && (emit || cmd.flush);
    assign emit_pos = (kind == dpld_pkg::STEP_START) ? start_pos_reg : sum;

    assign status.kind       = kind;
    assign status.n_full     = nres_reg == dpld_pkg::NRES_BITS'(dpld_pkg::MAX_RESULTS);
    assign status.resid_full = rcount_reg > dpld_pkg::RCOUNT_BITS'(dpld_pkg::WORD_BITS);
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = !out_valid_reg || m_ready;

    // Config registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_pos_reg   <= '0;
            value_count_reg <= '0;
            block_value_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                dpld_pkg::CFG_START_POSITION: start_pos_reg   <= cfg_data;
                dpld_pkg::CFG_VALUE_COUNT:    value_count_reg <= cfg_data;
                dpld_pkg::CFG_BLOCK_VALUE:    block_value_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // Residue payload: append the new word below the unread bits.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            residue_reg <= {residue_reg[dpld_pkg::WORD_BITS-1:0], word_in};
        end
    end

    // Decode state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcount_reg  <= '0;
            dwidth_reg  <= '0;
            wknown_reg  <= 1'b0;
            esc_reg     <= 1'b0;
            accum_reg   <= '0;
            emitted_reg <= '0;
            nres_reg    <= '0;
        end else if (cmd.restart) begin
            rcount_reg  <= '0;
            dwidth_reg  <= '0;
            wknown_reg  <= 1'b0;
            esc_reg     <= 1'b0;
            accum_reg   <= start_pos_reg;
            emitted_reg <= '0;
        end else if (cmd.load) begin
            rcount_reg <= rcount_reg + dpld_pkg::RCOUNT_BITS'(dpld_pkg::WORD_BITS);
            nres_reg   <= '0;
        end else if (cmd.exec) begin
            case (kind)
                dpld_pkg::STEP_WIDTH: begin
                    dwidth_reg <= field[dpld_pkg::WIDTH_BITS-1:0];
                    wknown_reg <= 1'b1;
                    rcount_reg <= shamt;
                end
                dpld_pkg::STEP_DONE: begin
                    // drop every remaining bit of a finished block
                    rcount_reg <= '0;
                end
                dpld_pkg::STEP_START: begin
                    accum_reg <= start_pos_reg;
                end
                dpld_pkg::STEP_ESC: begin
                    esc_reg    <= 1'b1;
                    rcount_reg <= shamt;
                end
                dpld_pkg::STEP_DELTA: begin
                    accum_reg  <= sum;
                    rcount_reg <= shamt;
                end
                dpld_pkg::STEP_RAW: begin
                    accum_reg  <= sum;
                    rcount_reg <= shamt;
                    esc_reg    <= 1'b0;
                end
                default: ;
            endcase
            if (emit) begin
                emitted_reg <= emitted_inc;
                nres_reg    <= nres_reg + 1'b1;
            end
        end
    end

    // Pending word: held back one step so the last word of an input can be marked.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (emit) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.flush) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            pend_pos_reg <= emit_pos;
            pend_lob_reg <= emitted_inc == value_count_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            out_pos_reg <= pend_pos_reg;
            out_val_reg <= block_value_reg;
            out_low_reg <= cmd.flush;
            out_lob_reg <= pend_lob_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_position      = out_pos_reg;
    assign m_item_value    = out_val_reg;
    assign m_last_of_word  = out_low_reg;
    assign m_last_of_block = out_lob_reg;

endmodule

// ===== design/dpld_ctrl.sv =====
// Controller: accepts input words and sequences decode steps and the final flush.
module dpld_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  dpld_pkg::dp_status_t status,
    output dpld_pkg::dp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb begin
        state_next  = state_reg;
        ready_next  = ready_reg;
        cmd.load    = 1'b0;
        cmd.restart = 1'b0;
        cmd.exec    = 1'b0;
        cmd.flush   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind) begin
                        cmd.restart = 1'b1;
                    end else if (!status.resid_full) begin
                        cmd.load   = 1'b1;
                        state_next = ST_STEP;
                        ready_next = 1'b0;
                    end
                    // a word that finds the residue full is dropped
                end
            end
            ST_STEP: begin
                if (status.n_full || status.kind == dpld_pkg::STEP_STALL) begin
                    state_next = ST_FLUSH;
                end else if (status.kind == dpld_pkg::STEP_DONE) begin
                    cmd.exec   = 1'b1;
                    state_next = ST_FLUSH;
                end else if (status.kind inside {dpld_pkg::STEP_START, dpld_pkg::STEP_DELTA,
                                                 dpld_pkg::STEP_RAW}) begin
                    // hold while the pending word has nowhere to go
                    cmd.exec = !status.pend_valid || status.out_free;
                end else begin
                    cmd.exec = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (!status.pend_valid || status.out_free) begin
                    cmd.flush  = status.pend_valid;
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

// ===== design/dpld_checker.sv =====
// Port-level checker for the delta position list decoder, bound to the top level.
`include "delta_position_list_decoder_top_assert.svh"

module dpld_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic                                  s_kind,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic [dpld_pkg::WORD_BITS-1:0]        m_position,
    input logic signed [dpld_pkg::WORD_BITS-1:0] m_item_value,
    input logic                                  m_last_of_word,
    input logic                                  m_last_of_block
);

    // A stalled output word holds its payload.
    `DPLD_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_position) && $stable(m_item_value) && $stable(m_last_of_word)
        && $stable(m_last_of_block), "output word changed while stalled")

    // A start item never produces an output word.
    `DPLD_ASSERT_NEXT(a_start_silent, s_valid && s_ready && s_kind && !m_valid, !m_valid,
        "start item produced an output word")

    // A stream word is loaded and decoded before its first output word shows.
    `DPLD_ASSERT_NEXT(a_word_latency, s_valid && s_ready && !s_kind && !m_valid, !m_valid,
        "output word appeared one cycle after a stream word")

    // The input side is closed while a stream word is being decoded.
    `DPLD_ASSERT_NEXT(a_busy_after_word, s_valid && s_ready && !s_kind, !s_ready,
        "input accepted during decode")

endmodule

bind delta_position_list_decoder_top dpld_checker u_dpld_checker (.*);

// ===== tb/tb_delta_position_list_decoder_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the delta position list decoder: directed and random streams.
module tb_delta_position_list_decoder_top;
    import dpld_pkg::*;

    localparam int          RAW_BITS      = 32;
    localparam int          SETTLE_CYCLES = 120;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          RANDOM_ITEMS  = 250;
    localparam int          QUIET_FROM    = 200;
    localparam int          MAX_PRINTS    = 20;
    localparam logic        KIND_WORD     = 1'b0;
    localparam logic        KIND_START    = 1'b1;

    typedef struct packed {
        logic [WORD_BITS-1:0]        position;
        logic signed [WORD_BITS-1:0] value;
        logic                        last_word;
        logic                        last_block;
    } position_result_t;

    logic                        aclk            = 1'b0;
    logic                        aresetn         = 1'b0;
    logic                        s_valid         = 1'b0;
    logic                        s_ready;
    logic                        s_kind          = KIND_WORD;
    logic [WORD_BITS-1:0]        s_stream_word   = '0;
    logic                        m_valid;
    logic                        m_ready         = 1'b0;
    logic [WORD_BITS-1:0]        m_position;
    logic signed [WORD_BITS-1:0] m_item_value;
    logic                        m_last_of_word;
    logic                        m_last_of_block;
    logic                        cfg_we          = 1'b0;
    logic [CFG_IDX_BITS-1:0]     cfg_index       = CFG_START_POSITION;
    logic [WORD_BITS-1:0]        cfg_data        = '0;

    // decoder image: configuration and stream state
    logic [WORD_BITS-1:0]        cfg_start = '0;
    logic [WORD_BITS-1:0]        cfg_count = '0;
    logic signed [WORD_BITS-1:0] cfg_value = '0;
    logic [RES_BITS-1:0]         res_bits  = '0;
    logic [RCOUNT_BITS-1:0]      res_cnt   = '0;
    logic [WIDTH_BITS-1:0]       dw        = '0;
    logic                        dw_known  = 1'b0;
    logic                        esc_pend  = 1'b0;
    logic [WORD_BITS-1:0]        pos_acc   = '0;
    logic [WORD_BITS-1:0]        n_emitted = '0;

    position_result_t expected_positions[$];
    position_result_t staged;
    bit               staged_ok = 1'b0;
    bit               stream_bits[$];

    bit idle_en          = 1'b1;
    int stall_left       = 0;
    int cycles           = 0;
    int errors           = 0;
    int items_sent       = 0;
    int positions_checked = 0;
    int blocks_run       = 0;

    delta_position_list_decoder_top #(
        .RAW_DELTA_BITS(RAW_BITS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_stream_word  (s_stream_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_position     (m_position),
        .m_item_value   (m_item_value),
        .m_last_of_word (m_last_of_word),
        .m_last_of_block(m_last_of_block),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d positions still expected",
                     cycles, expected_positions.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver starts stalls of random length at random while idle_en is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH cycle %0d: %s", cycles, what);
    endtask

    always @(posedge aclk) begin : check_results
        position_result_t want;
        if (aresetn && m_valid && m_ready) begin
            positions_checked++;
            if (expected_positions.size() == 0) begin
                report_mismatch($sformatf("unexpected word, position %h", m_position));
            end else begin
                want = expected_positions.pop_front();
                if (m_position !== want.position)
                    report_mismatch($sformatf("position %h, want %h",
                                              m_position, want.position));
                if (m_item_value !== want.value)
                    report_mismatch($sformatf("item_value %h, want %h",
                                              m_item_value, want.value));
                if (m_last_of_word !== want.last_word)
                    report_mismatch($sformatf("last_of_word %b, want %b at position %h",
                                              m_last_of_word, want.last_word, want.position));
                if (m_last_of_block !== want.last_block)
                    report_mismatch($sformatf("last_of_block %b, want %b at position %h",
                                              m_last_of_block, want.last_block,
                                              want.position));
            end
        end
    end

    function automatic logic [WORD_BITS-1:0] field_mask(input int unsigned n);
        if (n >= WORD_BITS)
            return '1;
        return WORD_BITS'((64'd1 << n) - 64'd1);
    endfunction

    // pop n bits off the top of the valid residue
    function automatic logic [WORD_BITS-1:0] take_bits(input int unsigned n);
        logic [RES_BITS-1:0] shifted;
        if (n == 0)
            return '0;
        shifted = res_bits >> (res_cnt - n);
        res_cnt = res_cnt - RCOUNT_BITS'(n);
        return shifted[WORD_BITS-1:0] & field_mask(n);
    endfunction

    function automatic void restart_block();
        res_bits  = '0;
        res_cnt   = '0;
        dw        = '0;
        dw_known  = 1'b0;
        esc_pend  = 1'b0;
        n_emitted = '0;
        pos_acc   = cfg_start;
    endfunction

    // hold one position back so the last one of the word can be flagged
    function automatic void stage_position();
        n_emitted++;
        if (staged_ok)
            expected_positions.push_back(staged);
        staged.position   = pos_acc;
        staged.value      = cfg_value;
        staged.last_word  = 1'b0;
        staged.last_block = (n_emitted == cfg_count);
        staged_ok         = 1'b1;
    endfunction

    function automatic void predict_positions(input logic kind, input logic [WORD_BITS-1:0] word);
        int              n;
        logic [WORD_BITS-1:0] f;
        n         = 0;
        staged_ok = 1'b0;
        if (kind == KIND_START) begin
            restart_block();
            return;
        end
        // residue full: drop the word
        if (res_cnt > RCOUNT_BITS'(WORD_BITS))
            return;
        res_bits = {res_bits[WORD_BITS-1:0], word};
        res_cnt  = res_cnt + RCOUNT_BITS'(WORD_BITS);
        while (n < MAX_RESULTS) begin
            if (!dw_known) begin
                if (res_cnt < RCOUNT_BITS'(WIDTH_BITS))
                    break;
                dw       = WIDTH_BITS'(take_bits(WIDTH_BITS));
                dw_known = 1'b1;
            end else if (n_emitted >= cfg_count) begin
                res_cnt  = '0;
                res_bits = '0;
                break;
            end else if (n_emitted == 0) begin
                pos_acc = cfg_start;
                stage_position();
                n++;
            end else if (!esc_pend) begin
                if (res_cnt < RCOUNT_BITS'(dw))
                    break;
                f = take_bits(dw);
                if (f == field_mask(dw)) begin
                    esc_pend = 1'b1;
                end else begin
                    pos_acc = pos_acc + f;
                    stage_position();
                    n++;
                end
            end else begin
                if (res_cnt < RCOUNT_BITS'(RAW_BITS))
                    break;
                pos_acc  = pos_acc + take_bits(RAW_BITS);
                esc_pend = 1'b0;
                stage_position();
                n++;
            end
        end
        if (staged_ok) begin
            staged.last_word = 1'b1;
            expected_positions.push_back(staged);
        end
    endfunction

    task automatic send_item(input logic kind, input logic [WORD_BITS-1:0] word);
        if (idle_en && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_stream_word <= word;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_positions(kind, word);
        items_sent++;
    endtask

    // drop valid, let every expected word arrive, then let the decode loop settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_positions.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [WORD_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_START_POSITION: cfg_start = data;
            CFG_VALUE_COUNT:    cfg_count = data;
            CFG_BLOCK_VALUE:    cfg_value = data;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure_block(input logic [WORD_BITS-1:0] start_pos,
                                   input logic [WORD_BITS-1:0] count,
                                   input logic [WORD_BITS-1:0] value);
        wait_idle();
        write_reg(CFG_START_POSITION, start_pos);
        write_reg(CFG_VALUE_COUNT, count);
        write_reg(CFG_BLOCK_VALUE, value);
        blocks_run++;
    endtask

    function automatic void put_bits(input logic [WORD_BITS-1:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            stream_bits.push_back(v[i]);
    endfunction

    // pad the tail of the stream with random bits
    function automatic logic [WORD_BITS-1:0] next_stream_word();
        logic [WORD_BITS-1:0] w;
        for (int i = WORD_BITS - 1; i >= 0; i--)
            w[i] = (stream_bits.size() != 0) ? stream_bits.pop_front() : 1'($urandom);
        return w;
    endfunction

    task automatic send_stream(input bit noisy);
        logic [WORD_BITS-1:0] w;
        while (stream_bits.size() != 0) begin
            w = next_stream_word();
            if (noisy && $urandom_range(0, 24) == 0)
                send_item(KIND_START, $urandom);
            if (noisy && $urandom_range(0, 11) == 0)
                w = $urandom;
            send_item(KIND_WORD, w);
        end
    endtask

    // reset config has count zero; raise it and hit the per-word result limit
    task automatic test_count_raised_after_reset();
        send_item(KIND_WORD, {5'd1, 27'd0});
        wait_idle();
        write_reg(CFG_VALUE_COUNT, 32'd40);
        send_item(KIND_WORD, 32'h0000_0000);
        send_item(KIND_WORD, 32'h0000_0000);
        send_item(KIND_WORD, 32'hFFFF_FFFF);
    endtask

    // widest deltas, escape with an all-ones raw delta, position wrap
    task automatic test_wide_deltas();
        configure_block(32'hFFFF_FFFF, 32'd4, 32'h8000_0000);
        send_item(KIND_START, $urandom);
        put_bits(32'd31, WIDTH_BITS);
        put_bits(32'h7FFF_FFFE, 31);
        put_bits(32'h7FFF_FFFF, 31);
        put_bits(32'hFFFF_FFFF, RAW_BITS);
        put_bits(32'h0, 31);
        send_stream(1'b0);
    endtask

    task automatic test_width_zero();
        configure_block(32'h0, 32'd3, 32'h7FFF_FFFF);
        send_item(KIND_START, $urandom);
        put_bits(32'd0, WIDTH_BITS);
        put_bits(32'hFFFF_FFFF, RAW_BITS);
        put_bits(32'h0000_0001, RAW_BITS);
        send_stream(1'b0);
    endtask

    // empty block, then a start item that cuts an escape short
    task automatic test_restart_mid_block();
        configure_block(32'h0000_1234, 32'd0, 32'h0);
        send_item(KIND_START, $urandom);
        send_item(KIND_WORD, $urandom);
        wait_idle();
        write_reg(CFG_VALUE_COUNT, 32'd6);
        send_item(KIND_START, $urandom);
        put_bits(32'd4, WIDTH_BITS);
        put_bits(32'd3, 4);
        put_bits(32'd15, 4);
        send_stream(1'b0);
        send_item(KIND_START, $urandom);
        put_bits(32'd2, WIDTH_BITS);
        put_bits(32'd1, 2);
        put_bits(32'd0, 2);
        put_bits(32'd3, 2);
        put_bits($urandom, RAW_BITS);
        put_bits(32'd2, 2);
        send_stream(1'b0);
    endtask

    // complete a block, raise the count, then run with the largest count
    task automatic test_raise_after_complete();
        configure_block(32'd100, 32'd2, 32'hFFFF_FFFF);
        send_item(KIND_START, $urandom);
        put_bits(32'd3, WIDTH_BITS);
        put_bits(32'd5, 3);
        put_bits(32'd6, 3);
        send_stream(1'b0);
        wait_idle();
        write_reg(CFG_VALUE_COUNT, 32'd5);
        put_bits(32'd1, 3);
        put_bits(32'd2, 3);
        put_bits(32'd7, 3);
        put_bits(32'h8000_0000, RAW_BITS);
        send_stream(1'b0);
        wait_idle();
        write_reg(CFG_VALUE_COUNT, 32'hFFFF_FFFF);
        send_item(KIND_WORD, $urandom);
        send_item(KIND_WORD, $urandom);
    endtask

    task automatic test_random_blocks();
        int                   base;
        int                   w;
        int                   n_deltas;
        int                   r;
        logic [WORD_BITS-1:0] start_pos;
        logic [WORD_BITS-1:0] count;
        logic [WORD_BITS-1:0] mask;
        logic [WORD_BITS-1:0] d;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (items_sent - base >= QUIET_FROM)
                idle_en = 1'b0;
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
            r = $urandom_range(0, 19);
            count = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom_range(1, 24);
            r = $urandom_range(0, 9);
            start_pos = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            configure_block(start_pos, count, $urandom);
            send_item(KIND_START, $urandom);
            put_bits(w, WIDTH_BITS);
            mask = field_mask(w);
            // for a count of 1 to 24, up to two surplus deltas past the end of the block; else 1 to 30 deltas
            n_deltas = (count == 0 || count > 24) ? $urandom_range(1, 30)
                                                  : count - 1 + $urandom_range(0, 2);
            for (int k = 0; k < n_deltas; k++) begin
                if (w == 0) begin
                    put_bits($urandom, RAW_BITS);
                end else if ($urandom_range(0, 7) == 0) begin
                    put_bits(mask, w);
                    put_bits($urandom, RAW_BITS);
                end else begin
                    r = $urandom_range(0, 5);
                    d = (r == 0) ? 32'h0 : (r == 1) ? mask - 1 : $urandom & mask;
                    if (d == mask)
                        d = mask - 1;
                    put_bits(d, w);
                end
            end
            send_stream(1'b1);
            if (count < 32'd1000 && $urandom_range(0, 7) == 0) begin
                wait_idle();
                write_reg(CFG_VALUE_COUNT, count + $urandom_range(1, 40));
                send_item(KIND_WORD, $urandom);
                send_item(KIND_WORD, $urandom);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_count_raised_after_reset();
        test_wide_deltas();
        test_width_zero();
        test_restart_mid_block();
        test_raise_after_complete();
        test_random_blocks();
        wait_idle();
        $display("Run covered %0d input items over %0d blocks, %0d positions checked,",
                 items_sent, blocks_run, positions_checked);
        $display("widths 0 to 31, escapes, restarts, empty and late-raised counts; %0d errors",
                 errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
